// File: hdl/mlm_pkg.sv
`default_nettype none

package mlm_pkg;

    // Field widths.
    localparam int LVL_W  = 12;
    localparam int NUM_W  = 8;
    localparam int DEN_W  = 9;
    localparam int PCT_W  = 7;
    localparam int THR_W  = 7;
    localparam int LED_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // Smoothing product width: 4095 * 255 + 4095 fits in 20 bits.
    localparam int PROD_W = 20;

    // Percentage mapping constants.
    localparam int PCT_DVD_W  = 18;
    localparam int PCT_DVS_W  = 11;
    localparam logic [LVL_W-1:0]     PCT_LO   = 12'd64;
    localparam logic [LVL_W-1:0]     PCT_HI   = 12'd1800;
    localparam logic [PCT_DVS_W-1:0] PCT_SPAN = 11'd1736;
    localparam int                   PCT_FULL = 100;

    localparam logic [LVL_W-1:0] LVL_MAX = 12'd4095;

    // LED bar codes.
    localparam logic [LED_W-1:0] LED_NONE  = 3'd0;
    localparam logic [LED_W-1:0] LED_ONE   = 3'd1;
    localparam logic [LED_W-1:0] LED_TWO   = 3'd2;
    localparam logic [LED_W-1:0] LED_THREE = 3'd3;
    localparam logic [LED_W-1:0] LED_FOUR  = 3'd4;

    // Register reset values.
    localparam logic [LVL_W-1:0] NOISE_FLOOR_RST = 12'd40;
    localparam logic [LVL_W-1:0] LED1_THR_RST    = 12'd200;
    localparam logic [LVL_W-1:0] LED2_THR_RST    = 12'd500;
    localparam logic [LVL_W-1:0] LED3_THR_RST    = 12'd900;
    localparam logic [LVL_W-1:0] LED4_THR_RST    = 12'd1400;
    localparam logic [NUM_W-1:0] SMOOTH_NUM_RST  = 8'd3;
    localparam logic [DEN_W-1:0] SMOOTH_DEN_RST  = 9'd4;
    localparam logic [THR_W-1:0] UPDATE_THR_RST  = 7'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_FLOOR = 3'd0,
        REG_LED1_THR    = 3'd1,
        REG_LED2_THR    = 3'd2,
        REG_LED3_THR    = 3'd3,
        REG_LED4_THR    = 3'd4,
        REG_SMOOTH_NUM  = 3'd5,
        REG_SMOOTH_DEN  = 3'd6,
        REG_UPDATE_THR  = 3'd7
    } cfg_index_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// File: hdl/mlm_serial_mul.sv
`default_nettype none

// Shift-and-add multiplier, one multiplier bit per cycle, with an addend
// preloaded into the accumulator.
module mlm_serial_mul (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            start,
    input  wire [mlm_pkg::LVL_W-1:0]       mcand,
    input  wire [mlm_pkg::NUM_W-1:0]       mplier,
    input  wire [mlm_pkg::LVL_W-1:0]       addend,
    output logic                           busy,
    output logic [mlm_pkg::PROD_W-1:0]     product
);

    localparam int CNT_W = $clog2(mlm_pkg::NUM_W + 1);

    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [mlm_pkg::PROD_W-1:0]  acc_reg;
    logic [mlm_pkg::PROD_W-1:0]  mc_reg;
    logic [mlm_pkg::NUM_W-1:0]   mp_reg;

    // Control: stay busy until every multiplier bit has been used.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(mlm_pkg::NUM_W);
        end else if (busy_reg) begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // Datapath: add the shifted multiplicand when the low multiplier bit is set.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= mlm_pkg::PROD_W'(addend);
            mc_reg  <= mlm_pkg::PROD_W'(mcand);
            mp_reg  <= mplier;
        end else if (busy_reg) begin
            if (mp_reg[0]) begin
                acc_reg <= acc_reg + mc_reg;
            end
            mc_reg <= {mc_reg[mlm_pkg::PROD_W-2:0], 1'b0};
            mp_reg <= {1'b0, mp_reg[mlm_pkg::NUM_W-1:1]};
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// File: hdl/mlm_serial_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant first.
module mlm_serial_div #(
    parameter int DVD_W = 20,
    parameter int DVS_W = 9
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               start,
    input  wire [DVD_W-1:0]   dividend,
    input  wire [DVS_W-1:0]   divisor,
    output logic              busy,
    output logic [DVD_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic               busy_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DVS_W-1:0]   rem_reg;
    logic [DVS_W-1:0]   dvs_reg;
    logic [DVD_W-1:0]   quo_reg;
    logic [DVS_W:0]     trial;
    logic               fits;

    // Shift the next dividend bit into the partial remainder and test it.
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    // Control: stay busy until every dividend bit has been shifted through.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DVD_W);
        end else if (busy_reg) begin
            busy_reg <= (cnt_reg != CNT_W'(1));
            cnt_reg  <= cnt_reg - CNT_W'(1);
        end
    end

    // Datapath: dividend bits leave at the top while quotient bits enter below.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= DVS_W'(trial - {1'b0, dvs_reg});
            end else begin
                rem_reg <= trial[DVS_W-1:0];
            end
            quo_reg <= {quo_reg[DVD_W-2:0], fits};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: hdl/mic_loudness_meter.sv
`default_nettype none

// Channel   | Handshake                  | Beat contents
// ----------+----------------------------+-------------------------------------------
// input     | s_valid / s_ready          | s_raw_level
// result    | m_valid / m_ready          | m_clean_level .. m_send_update
// config    | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// An input beat is accepted only in idle; the sequencer then runs the multiply beside
// the percentage divide, then the smoothing divide beside the block-average divide,
// each phase waiting for both of its units, loads the result register and returns
// to idle, where it takes the next beat. A result that waits in the result register
// holds the sequencer. Reset is synchronous and active low; config is always ready.
module mic_loudness_meter #(
    parameter int BLOCK_LEN = 20
) (
    input  wire                             aclk,
    input  wire                             aresetn,

    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire [mlm_pkg::LVL_W-1:0]        s_raw_level,

    output logic                            m_valid,
    input  wire                             m_ready,
    output logic [mlm_pkg::LVL_W-1:0]       m_clean_level,
    output logic [mlm_pkg::LVL_W-1:0]       m_iir_level,
    output logic [mlm_pkg::LVL_W-1:0]       m_peak_level,
    output logic [mlm_pkg::LED_W-1:0]       m_led_count,
    output logic [mlm_pkg::PCT_W-1:0]       m_percentage,
    output logic                            m_block_done,
    output logic [mlm_pkg::PCT_W-1:0]       m_block_pct,
    output logic                            m_send_update,

    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [mlm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [mlm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IDX_W     = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
    localparam int SUM_W     = $clog2(BLOCK_LEN * mlm_pkg::PCT_FULL + 1);
    localparam int AVG_DVS_W = $clog2(BLOCK_LEN + 1);

    // Configuration registers.
    logic [mlm_pkg::LVL_W-1:0] noise_floor_reg;
    logic [mlm_pkg::LVL_W-1:0] led1_thr_reg;
    logic [mlm_pkg::LVL_W-1:0] led2_thr_reg;
    logic [mlm_pkg::LVL_W-1:0] led3_thr_reg;
    logic [mlm_pkg::LVL_W-1:0] led4_thr_reg;
    logic [mlm_pkg::NUM_W-1:0] smooth_num_reg;
    logic [mlm_pkg::DEN_W-1:0] smooth_den_reg;
    logic [mlm_pkg::THR_W-1:0] update_thr_reg;

    // Meter state.
    logic [mlm_pkg::LVL_W-1:0] smooth_reg;
    logic [mlm_pkg::LVL_W-1:0] peak_reg;
    logic [IDX_W-1:0]          sample_idx_reg;
    logic [SUM_W-1:0]          percent_sum_reg;
    logic [mlm_pkg::PCT_W-1:0] last_sent_reg;

    mlm_pkg::state_t state_reg, state_next;

    logic [mlm_pkg::LVL_W-1:0] filt_reg;

    // Result register.
    logic                      m_valid_reg;
    logic [mlm_pkg::LVL_W-1:0] out_filt_reg;
    logic [mlm_pkg::LVL_W-1:0] out_smooth_reg;
    logic [mlm_pkg::LVL_W-1:0] out_peak_reg;
    logic [mlm_pkg::LED_W-1:0] out_led_reg;
    logic [mlm_pkg::PCT_W-1:0] out_pct_reg;
    logic                      out_done_reg;
    logic [mlm_pkg::PCT_W-1:0] out_avg_reg;
    logic                      out_send_reg;

    logic accept, start_mul, start_div, load_out;

    logic                        mul_busy, sdiv_busy, pdiv_busy, adiv_busy;
    logic [mlm_pkg::PROD_W-1:0]  product, smooth_quo;
    logic [mlm_pkg::PCT_DVD_W-1:0] pct_dvd, pct_quo;
    logic [SUM_W-1:0]            avg_quo;

    logic [mlm_pkg::LVL_W-1:0]   filt_now;
    logic [mlm_pkg::LVL_W-1:0]   clamp_now;
    logic [mlm_pkg::PCT_DVS_W-1:0] span_now;
    logic [mlm_pkg::DEN_W-1:0]   den_eff;
    logic [mlm_pkg::LVL_W-1:0]   sm_sat;
    logic [mlm_pkg::LVL_W+1:0]   peak_mix;
    logic [mlm_pkg::LVL_W-1:0]   peak_new;
    logic [mlm_pkg::LED_W-1:0]   led_new;
    logic [mlm_pkg::PCT_W-1:0]   pct_new;
    logic [SUM_W-1:0]            sum_new;
    logic                        block_end;
    logic [mlm_pkg::PCT_W-1:0]   avg_new;
    logic [mlm_pkg::PCT_W-1:0]   avg_diff;
    logic                        send_new;

    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_floor_reg <= mlm_pkg::NOISE_FLOOR_RST;
            led1_thr_reg    <= mlm_pkg::LED1_THR_RST;
            led2_thr_reg    <= mlm_pkg::LED2_THR_RST;
            led3_thr_reg    <= mlm_pkg::LED3_THR_RST;
            led4_thr_reg    <= mlm_pkg::LED4_THR_RST;
            smooth_num_reg  <= mlm_pkg::SMOOTH_NUM_RST;
            smooth_den_reg  <= mlm_pkg::SMOOTH_DEN_RST;
            update_thr_reg  <= mlm_pkg::UPDATE_THR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (mlm_pkg::cfg_index_t'(cfg_index))
                mlm_pkg::REG_NOISE_FLOOR: noise_floor_reg <= cfg_data;
                mlm_pkg::REG_LED1_THR:    led1_thr_reg    <= cfg_data;
                mlm_pkg::REG_LED2_THR:    led2_thr_reg    <= cfg_data;
                mlm_pkg::REG_LED3_THR:    led3_thr_reg    <= cfg_data;
                mlm_pkg::REG_LED4_THR:    led4_thr_reg    <= cfg_data;
                mlm_pkg::REG_SMOOTH_NUM:  smooth_num_reg  <= cfg_data[mlm_pkg::NUM_W-1:0];
                mlm_pkg::REG_SMOOTH_DEN:  smooth_den_reg  <= cfg_data[mlm_pkg::DEN_W-1:0];
                mlm_pkg::REG_UPDATE_THR:  update_thr_reg  <= cfg_data[mlm_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Noise floor subtraction, clamped at zero.
    assign filt_now = (s_raw_level > noise_floor_reg) ? s_raw_level - noise_floor_reg
                                                      : '0;

    // Percentage dividend: (clamp(filtered, 64, 1800) - 64) * 100 by shifts.
    always_comb begin
        if (filt_now > mlm_pkg::PCT_HI) begin
            clamp_now = mlm_pkg::PCT_HI;
        end else if (filt_now < mlm_pkg::PCT_LO) begin
            clamp_now = mlm_pkg::PCT_LO;
        end else begin
            clamp_now = filt_now;
        end
        span_now = mlm_pkg::PCT_DVS_W'(clamp_now - mlm_pkg::PCT_LO);
        pct_dvd  = (mlm_pkg::PCT_DVD_W'(span_now) << 6)
                 + (mlm_pkg::PCT_DVD_W'(span_now) << 5)
                 + (mlm_pkg::PCT_DVD_W'(span_now) << 2);
    end

    // A zero denominator divides by one.
    assign den_eff = (smooth_den_reg == '0) ? mlm_pkg::DEN_W'(1) : smooth_den_reg;

    mlm_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_mul),
        .mcand   (smooth_reg),
        .mplier  (smooth_num_reg),
        .addend  (filt_now),
        .busy    (mul_busy),
        .product (product)
    );

    mlm_serial_div #(
        .DVD_W (mlm_pkg::PCT_DVD_W),
        .DVS_W (mlm_pkg::PCT_DVS_W)
    ) u_pct_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_mul),
        .dividend (pct_dvd),
        .divisor  (mlm_pkg::PCT_SPAN),
        .busy     (pdiv_busy),
        .quotient (pct_quo)
    );

    mlm_serial_div #(
        .DVD_W (mlm_pkg::PROD_W),
        .DVS_W (mlm_pkg::DEN_W)
    ) u_smooth_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_div),
        .dividend (product),
        .divisor  (den_eff),
        .busy     (sdiv_busy),
        .quotient (smooth_quo)
    );

    // Running block sum including this beat's percentage.
    assign pct_new = pct_quo[mlm_pkg::PCT_W-1:0];
    assign sum_new = percent_sum_reg + SUM_W'(pct_new);

    mlm_serial_div #(
        .DVD_W (SUM_W),
        .DVS_W (AVG_DVS_W)
    ) u_avg_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_div),
        .dividend (sum_new),
        .divisor  (AVG_DVS_W'(BLOCK_LEN)),
        .busy     (adiv_busy),
        .quotient (avg_quo)
    );

    // Smoothed level saturates at full scale.
    assign sm_sat = (|smooth_quo[mlm_pkg::PROD_W-1:mlm_pkg::LVL_W]) ? mlm_pkg::LVL_MAX
                                                                    : smooth_quo[mlm_pkg::LVL_W-1:0];

    // Peak follower: fast attack, otherwise (3 * peak + filtered) / 4.
    assign peak_mix = (mlm_pkg::LVL_W+2)'(peak_reg)
                    + ((mlm_pkg::LVL_W+2)'(peak_reg) << 1)
                    + (mlm_pkg::LVL_W+2)'(filt_reg);
    assign peak_new = (filt_reg > peak_reg) ? filt_reg : peak_mix[mlm_pkg::LVL_W+1:2];

    // LED bar: the highest threshold met wins.
    always_comb begin
        if (sm_sat >= led4_thr_reg) begin
            led_new = mlm_pkg::LED_FOUR;
        end else if (sm_sat >= led3_thr_reg) begin
            led_new = mlm_pkg::LED_THREE;
        end else if (sm_sat >= led2_thr_reg) begin
            led_new = mlm_pkg::LED_TWO;
        end else if (sm_sat >= led1_thr_reg) begin
            led_new = mlm_pkg::LED_ONE;
        end else begin
            led_new = mlm_pkg::LED_NONE;
        end
    end

    // Block end, average and update decision.
    assign block_end = (sample_idx_reg == IDX_W'(BLOCK_LEN - 1));
    assign avg_new   = block_end ? avg_quo[mlm_pkg::PCT_W-1:0] : '0;
    assign avg_diff  = (avg_new > last_sent_reg) ? avg_new - last_sent_reg
                                                 : last_sent_reg - avg_new;
    assign send_new  = block_end && (avg_diff > update_thr_reg);

    // Sequencer next state and strobes.
    always_comb begin
        state_next = state_reg;
        accept     = 1'b0;
        start_mul  = 1'b0;
        start_div  = 1'b0;
        load_out   = 1'b0;
        s_ready    = 1'b0;
        case (state_reg)
            mlm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    accept     = 1'b1;
                    start_mul  = 1'b1;
                    state_next = mlm_pkg::ST_MUL;
                end
            end
            mlm_pkg::ST_MUL: begin
                if (!mul_busy && !pdiv_busy) begin
                    start_div  = 1'b1;
                    state_next = mlm_pkg::ST_DIV;
                end
            end
            mlm_pkg::ST_DIV: begin
                if (!sdiv_busy && !adiv_busy) begin
                    state_next = mlm_pkg::ST_OUT;
                end
            end
            mlm_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = mlm_pkg::ST_IDLE;
                end
            end
            default: state_next = mlm_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mlm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Filtered level of the beat in flight.
    always_ff @(posedge aclk) begin
        if (accept) begin
            filt_reg <= filt_now;
        end
    end

    // Meter state commits when the result is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smooth_reg      <= '0;
            peak_reg        <= '0;
            sample_idx_reg  <= '0;
            percent_sum_reg <= '0;
            last_sent_reg   <= '0;
        end else if (load_out) begin
            smooth_reg <= sm_sat;
            peak_reg   <= peak_new;
            if (block_end) begin
                sample_idx_reg  <= '0;
                percent_sum_reg <= '0;
            end else begin
                sample_idx_reg  <= sample_idx_reg + IDX_W'(1);
                percent_sum_reg <= sum_new;
            end
            if (send_new) begin
                last_sent_reg <= avg_new;
            end
        end
    end

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_filt_reg   <= filt_reg;
            out_smooth_reg <= sm_sat;
            out_peak_reg   <= peak_new;
            out_led_reg    <= led_new;
            out_pct_reg    <= pct_new;
            out_done_reg   <= block_end;
            out_avg_reg    <= avg_new;
            out_send_reg   <= send_new;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_clean_level = out_filt_reg;
    assign m_iir_level   = out_smooth_reg;
    assign m_peak_level  = out_peak_reg;
    assign m_led_count   = out_led_reg;
    assign m_percentage  = out_pct_reg;
    assign m_block_done  = out_done_reg;
    assign m_block_pct   = out_avg_reg;
    assign m_send_update = out_send_reg;

endmodule

`default_nettype wire

// File: hdl/mlm_checker.sv
`default_nettype none

// Port-level checks on the meter's result and input channels.
module mlm_port_asserts (
    input wire                             aclk,
    input wire                             aresetn,
    input wire                             s_valid,
    input wire                             s_ready,
    input wire                             m_valid,
    input wire                             m_ready,
    input wire [mlm_pkg::LED_W-1:0]        m_led_count,
    input wire [mlm_pkg::PCT_W-1:0]        m_percentage,
    input wire                             m_block_done,
    input wire [mlm_pkg::PCT_W-1:0]        m_block_pct,
    input wire                             m_send_update
);

    // A stalled result beat stays valid and holds its LED count, percentages and block flags.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_led_count)
            && $stable(m_percentage) && $stable(m_block_pct)
            && $stable(m_block_done) && $stable(m_send_update))
        else $error("result beat changed while stalled");

    // No result appears right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // LED count and percentages stay within range.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_led_count <= 3'd4 && m_percentage <= 7'd100
            && m_block_pct <= 7'd100)
        else $error("result field out of range");

    // Average and update flag only accompany a block end.
    a_block: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_block_done |-> m_block_pct == 7'd0 && !m_send_update)
        else $error("average or update outside block end");

    // No two input beats are taken back to back.
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted in back-to-back cycles");

endmodule

bind mic_loudness_meter mlm_port_asserts u_mlm_port_asserts (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_led_count   (m_led_count),
    .m_percentage  (m_percentage),
    .m_block_done  (m_block_done),
    .m_block_pct   (m_block_pct),
    .m_send_update (m_send_update)
);

`default_nettype wire

// File: tb/sv/mlm_checker.sv
`timescale 1ns / 1ps

module mlm_checker #(
    parameter int BLOCK_LEN = 20
) (
    input  wire                              aclk,
    input  wire                              aresetn,

    input  wire                              s_valid,
    input  wire                              s_ready,
    input  wire [mlm_pkg::LVL_W-1:0]         s_raw_level,

    input  wire                              m_valid,
    input  wire                              m_ready,
    input  wire [mlm_pkg::LVL_W-1:0]         m_clean_level,
    input  wire [mlm_pkg::LVL_W-1:0]         m_iir_level,
    input  wire [mlm_pkg::LVL_W-1:0]         m_peak_level,
    input  wire [mlm_pkg::LED_W-1:0]         m_led_count,
    input  wire [mlm_pkg::PCT_W-1:0]         m_percentage,
    input  wire                              m_block_done,
    input  wire [mlm_pkg::PCT_W-1:0]         m_block_pct,
    input  wire                              m_send_update,

    input  wire                              cfg_valid,
    input  wire                              cfg_ready,
    input  wire [mlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [mlm_pkg::CFG_DATA_W-1:0]    cfg_data,

    output int                               error_count,
    output int                               readings_pending,
    output int                               blocks_seen,
    output int                               updates_seen
);

    // One meter reading as it leaves the block.
    typedef struct packed {
        logic [mlm_pkg::LVL_W-1:0] filtered;
        logic [mlm_pkg::LVL_W-1:0] smoothed;
        logic [mlm_pkg::LVL_W-1:0] peak;
        logic [mlm_pkg::LED_W-1:0] leds;
        logic [mlm_pkg::PCT_W-1:0] pct;
        logic                      done;
        logic [mlm_pkg::PCT_W-1:0] avg;
        logic                      send;
    } meter_reading_t;

    // Local copy of the configuration registers.
    logic [mlm_pkg::LVL_W-1:0] noise_floor;
    logic [mlm_pkg::LVL_W-1:0] led_thr [1:4];
    logic [mlm_pkg::NUM_W-1:0] smooth_num;
    logic [mlm_pkg::DEN_W-1:0] smooth_den;
    logic [mlm_pkg::THR_W-1:0] update_thr;

    // Local copy of the meter state.
    logic [mlm_pkg::LVL_W-1:0] smooth_lvl;
    logic [mlm_pkg::LVL_W-1:0] peak_lvl;
    logic [5:0]                sample_idx;
    logic [12:0]               percent_sum;
    logic [mlm_pkg::PCT_W-1:0] last_sent;

    meter_reading_t readings_due [$];
    int mismatches = 0;
    int results_seen = 0;
    int blocks_done = 0;
    int updates_done = 0;

    task automatic report_mismatch(input string what);
        $display("check: result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    // Runs one level through the meter and returns the reading it should give.
    function automatic meter_reading_t advance_meter(input logic [mlm_pkg::LVL_W-1:0] raw);
        meter_reading_t res;
        int unsigned filt, den, sm, pk, clamped, pct, avg, diff;
        filt = (raw <= noise_floor) ? 0 : 32'(raw - noise_floor);

        // A zero divisor behaves as one; the smoothed level saturates.
        den = (smooth_den == '0) ? 1 : 32'(smooth_den);
        sm = (32'(smooth_lvl) * 32'(smooth_num) + filt) / den;
        if (sm > 32'(mlm_pkg::LVL_MAX)) sm = 32'(mlm_pkg::LVL_MAX);
        smooth_lvl = mlm_pkg::LVL_W'(sm);

        // Fast attack, three-quarter decay.
        pk = (filt > 32'(peak_lvl)) ? filt : (3 * 32'(peak_lvl) + filt) / 4;
        peak_lvl = mlm_pkg::LVL_W'(pk);

        if (filt > 32'(mlm_pkg::PCT_HI)) clamped = 32'(mlm_pkg::PCT_HI);
        else if (filt < 32'(mlm_pkg::PCT_LO)) clamped = 32'(mlm_pkg::PCT_LO);
        else clamped = filt;
        pct = ((clamped - 32'(mlm_pkg::PCT_LO)) * 32'(mlm_pkg::PCT_FULL))
            / 32'(mlm_pkg::PCT_SPAN);
        percent_sum = 13'(32'(percent_sum) + pct);

        res.filtered = mlm_pkg::LVL_W'(filt);
        res.smoothed = mlm_pkg::LVL_W'(sm);
        res.peak     = peak_lvl;
        res.pct      = mlm_pkg::PCT_W'(pct);

        // Thresholds are tried from the top bar down; the first one met wins.
        if (sm >= 32'(led_thr[4]))      res.leds = mlm_pkg::LED_FOUR;
        else if (sm >= 32'(led_thr[3])) res.leds = mlm_pkg::LED_THREE;
        else if (sm >= 32'(led_thr[2])) res.leds = mlm_pkg::LED_TWO;
        else if (sm >= 32'(led_thr[1])) res.leds = mlm_pkg::LED_ONE;
        else                            res.leds = mlm_pkg::LED_NONE;

        res.done = 1'b0;
        res.avg  = '0;
        res.send = 1'b0;
        if (32'(sample_idx) + 1 >= BLOCK_LEN) begin
            avg = (32'(percent_sum) / BLOCK_LEN) & 32'h7F;
            diff = (avg > 32'(last_sent)) ? avg - 32'(last_sent) : 32'(last_sent) - avg;
            res.done = 1'b1;
            res.avg  = mlm_pkg::PCT_W'(avg);
            if (diff > 32'(update_thr)) begin
                res.send  = 1'b1;
                last_sent = mlm_pkg::PCT_W'(avg);
            end
            sample_idx  = '0;
            percent_sum = '0;
        end else begin
            sample_idx = sample_idx + 6'd1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        meter_reading_t got, want;
        if (!aresetn) begin
            noise_floor = mlm_pkg::NOISE_FLOOR_RST;
            led_thr[1]  = mlm_pkg::LED1_THR_RST;
            led_thr[2]  = mlm_pkg::LED2_THR_RST;
            led_thr[3]  = mlm_pkg::LED3_THR_RST;
            led_thr[4]  = mlm_pkg::LED4_THR_RST;
            smooth_num  = mlm_pkg::SMOOTH_NUM_RST;
            smooth_den  = mlm_pkg::SMOOTH_DEN_RST;
            update_thr  = mlm_pkg::UPDATE_THR_RST;
            smooth_lvl  = '0;
            peak_lvl    = '0;
            sample_idx  = '0;
            percent_sum = '0;
            last_sent   = '0;
            readings_due.delete();
        end else begin
            // Register writes; each register keeps only its own width.
            if (cfg_valid && cfg_ready) begin
                case (mlm_pkg::cfg_index_t'(cfg_index))
                    mlm_pkg::REG_NOISE_FLOOR: noise_floor = cfg_data;
                    mlm_pkg::REG_LED1_THR:    led_thr[1]  = cfg_data;
                    mlm_pkg::REG_LED2_THR:    led_thr[2]  = cfg_data;
                    mlm_pkg::REG_LED3_THR:    led_thr[3]  = cfg_data;
                    mlm_pkg::REG_LED4_THR:    led_thr[4]  = cfg_data;
                    mlm_pkg::REG_SMOOTH_NUM:  smooth_num  = cfg_data[mlm_pkg::NUM_W-1:0];
                    mlm_pkg::REG_SMOOTH_DEN:  smooth_den  = cfg_data[mlm_pkg::DEN_W-1:0];
                    mlm_pkg::REG_UPDATE_THR:  update_thr  = cfg_data[mlm_pkg::THR_W-1:0];
                    default: ;
                endcase
            end

            // Compare each result beat with the oldest reading due.
            if (m_valid && m_ready) begin
                got.filtered = m_clean_level;
                got.smoothed = m_iir_level;
                got.peak     = m_peak_level;
                got.leds     = m_led_count;
                got.pct      = m_percentage;
                got.done     = m_block_done;
                got.avg      = m_block_pct;
                got.send     = m_send_update;
                if (readings_due.size() == 0) begin
                    report_mismatch("result beat with no reading due");
                end else begin
                    want = readings_due.pop_front();
                    check_field("clean_level", 32'(got.filtered), 32'(want.filtered));
                    check_field("iir_level", 32'(got.smoothed), 32'(want.smoothed));
                    check_field("peak_level", 32'(got.peak), 32'(want.peak));
                    check_field("led_count", 32'(got.leds), 32'(want.leds));
                    check_field("percentage", 32'(got.pct), 32'(want.pct));
                    check_field("block_done", 32'(got.done), 32'(want.done));
                    check_field("block_pct", 32'(got.avg), 32'(want.avg));
                    check_field("send_update", 32'(got.send), 32'(want.send));
                    if (want.done) blocks_done++;
                    if (want.send) updates_done++;
                end
                results_seen++;
            end

            if (s_valid && s_ready) begin
                readings_due.push_back(advance_meter(s_raw_level));
            end
        end
        readings_pending <= readings_due.size();
        error_count      <= mismatches;
        blocks_seen      <= blocks_done;
        updates_seen     <= updates_done;
    end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int BLOCK_LEN       = 20;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int SETTLE_CYCLES   = 100;
    localparam int CYCLE_LIMIT     = 1000000;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                           s_valid     = 1'b0;
    logic                           s_ready;
    logic [mlm_pkg::LVL_W-1:0]      s_raw_level = '0;

    logic                           m_valid;
    logic                           m_ready     = 1'b0;
    logic [mlm_pkg::LVL_W-1:0]      m_clean_level;
    logic [mlm_pkg::LVL_W-1:0]      m_iir_level;
    logic [mlm_pkg::LVL_W-1:0]      m_peak_level;
    logic [mlm_pkg::LED_W-1:0]      m_led_count;
    logic [mlm_pkg::PCT_W-1:0]      m_percentage;
    logic                           m_block_done;
    logic [mlm_pkg::PCT_W-1:0]      m_block_pct;
    logic                           m_send_update;

    logic                           cfg_valid   = 1'b0;
    logic                           cfg_ready;
    logic [mlm_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [mlm_pkg::CFG_DATA_W-1:0] cfg_data    = '0;

    int error_count;
    int readings_pending;
    int blocks_seen;
    int updates_seen;

    int  cycle_count = 0;
    int  stall_left  = 0;
    int  levels_sent = 0;
    int  reg_writes  = 0;
    int  settings    = 0;
    // When set, neither side idles.
    bit  steady      = 1'b0;

    always #1 aclk = ~aclk;

    mic_loudness_meter #(
        .BLOCK_LEN(BLOCK_LEN)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_level   (s_raw_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_clean_level (m_clean_level),
        .m_iir_level   (m_iir_level),
        .m_peak_level  (m_peak_level),
        .m_led_count   (m_led_count),
        .m_percentage  (m_percentage),
        .m_block_done  (m_block_done),
        .m_block_pct   (m_block_pct),
        .m_send_update (m_send_update),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mlm_checker #(
        .BLOCK_LEN(BLOCK_LEN)
    ) u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_level      (s_raw_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_clean_level    (m_clean_level),
        .m_iir_level      (m_iir_level),
        .m_peak_level     (m_peak_level),
        .m_led_count      (m_led_count),
        .m_percentage     (m_percentage),
        .m_block_done     (m_block_done),
        .m_block_pct      (m_block_pct),
        .m_send_update    (m_send_update),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .error_count      (error_count),
        .readings_pending (readings_pending),
        .blocks_seen      (blocks_seen),
        .updates_seen     (updates_seen)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_cycles();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Random register values, with both ends of the field often.
    function automatic logic [mlm_pkg::CFG_DATA_W-1:0] pick_setting(
        input mlm_pkg::cfg_index_t idx);
        int unsigned r;
        r = $urandom_range(0, 3);
        if (r == 0) return '0;
        if (r == 1) return '1;
        case (idx)
            mlm_pkg::REG_NOISE_FLOOR: return mlm_pkg::CFG_DATA_W'($urandom_range(0, 600));
            mlm_pkg::REG_SMOOTH_NUM:  return mlm_pkg::CFG_DATA_W'($urandom_range(0, 4095));
            mlm_pkg::REG_SMOOTH_DEN:  return mlm_pkg::CFG_DATA_W'($urandom_range(1, 300));
            mlm_pkg::REG_UPDATE_THR:  return mlm_pkg::CFG_DATA_W'($urandom_range(0, 110));
            default:                  return mlm_pkg::CFG_DATA_W'($urandom_range(0, 2500));
        endcase
    endfunction

    // Levels cluster around a loudness that moves from block to block.
    function automatic logic [mlm_pkg::LVL_W-1:0] pick_level(input int unsigned center);
        int unsigned r, lo;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? '1 : '0;
        if (r < 3) return mlm_pkg::LVL_W'($urandom_range(0, 4095));
        if (r == 3) return mlm_pkg::LVL_W'($urandom_range(0, 150));
        lo = (center > 400) ? center - 400 : 0;
        return mlm_pkg::LVL_W'($urandom_range(lo, center + 400));
    endfunction

    // The result side stalls at random.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (!steady && $urandom_range(0, 11) == 0) stall_left <= gap_cycles();
        end
    end

    // Run limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // One input beat; valid stays high afterwards unless a gap follows.
    task automatic send_level(input logic [mlm_pkg::LVL_W-1:0] lvl);
        int gap;
        gap = gap_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_raw_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        levels_sent++;
    endtask

    // One register write beat; the caller lowers valid after the batch.
    task automatic write_reg(input mlm_pkg::cfg_index_t idx,
                             input logic [mlm_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        reg_writes++;
    endtask

    task automatic close_writes();
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings++;
    endtask

    // Stops input and waits for every reading due.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (readings_pending != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned center;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settings = 1;

        // Reset settings: floor edges, percentage clamp edges, attack and decay.
        send_level(12'd0);
        send_level(12'd40);
        send_level(12'd41);
        send_level(12'd104);
        send_level(12'd105);
        send_level(12'd1840);
        send_level(12'd1841);
        send_level(12'd4095);
        send_level(12'd0);
        send_level(12'd0);
        send_level(12'd0);
        send_level(12'd2000);
        wait_for_results();

        // Zero divisor with the largest weight saturates; unordered LED
        // thresholds; an update threshold above 100 never flags.
        write_reg(mlm_pkg::REG_NOISE_FLOOR, 12'h000);
        write_reg(mlm_pkg::REG_LED1_THR, 12'hFFF);
        write_reg(mlm_pkg::REG_LED2_THR, 12'h000);
        write_reg(mlm_pkg::REG_LED3_THR, 12'h800);
        write_reg(mlm_pkg::REG_LED4_THR, 12'hFFF);
        write_reg(mlm_pkg::REG_SMOOTH_NUM, 12'hFFF);
        write_reg(mlm_pkg::REG_SMOOTH_DEN, 12'hE00);
        write_reg(mlm_pkg::REG_UPDATE_THR, 12'hFFF);
        close_writes();
        send_level(12'd4095);
        send_level(12'd4095);
        send_level(12'd1);
        send_level(12'd0);
        send_level(12'd2048);
        send_level(12'd100);
        wait_for_results();

        // Divisor above 256, zero update threshold, floor at the top.
        write_reg(mlm_pkg::REG_SMOOTH_DEN, 12'h1FF);
        write_reg(mlm_pkg::REG_UPDATE_THR, 12'h000);
        write_reg(mlm_pkg::REG_LED1_THR, 12'd1);
        close_writes();
        send_level(12'd4095);
        send_level(12'd3000);
        wait_for_results();
        write_reg(mlm_pkg::REG_NOISE_FLOOR, 12'hFFF);
        close_writes();
        send_level(12'd4095);
        send_level(12'd0);
        send_level(12'd1000);
        wait_for_results();

        // Random phases, the first back on the reset settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_results();
            steady = (phase % 4 == 3);
            if (phase == 0) begin
                write_reg(mlm_pkg::REG_NOISE_FLOOR, mlm_pkg::NOISE_FLOOR_RST);
                write_reg(mlm_pkg::REG_LED1_THR, mlm_pkg::LED1_THR_RST);
                write_reg(mlm_pkg::REG_LED2_THR, mlm_pkg::LED2_THR_RST);
                write_reg(mlm_pkg::REG_LED3_THR, mlm_pkg::LED3_THR_RST);
                write_reg(mlm_pkg::REG_LED4_THR, mlm_pkg::LED4_THR_RST);
                write_reg(mlm_pkg::REG_SMOOTH_NUM,
                          mlm_pkg::CFG_DATA_W'(mlm_pkg::SMOOTH_NUM_RST));
                write_reg(mlm_pkg::REG_SMOOTH_DEN,
                          mlm_pkg::CFG_DATA_W'(mlm_pkg::SMOOTH_DEN_RST));
                write_reg(mlm_pkg::REG_UPDATE_THR,
                          mlm_pkg::CFG_DATA_W'(mlm_pkg::UPDATE_THR_RST));
            end else begin
                for (int idx = 0; idx < 8; idx++) begin
                    if ($urandom_range(0, 1) == 1) begin
                        write_reg(mlm_pkg::cfg_index_t'(idx),
                                  pick_setting(mlm_pkg::cfg_index_t'(idx)));
                    end
                end
            end
            close_writes();
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % BLOCK_LEN == 0) center = $urandom_range(0, 2300);
                send_level(pick_level(center));
            end
        end

        wait_for_results();
        steady = 1'b0;
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("summary: %0d levels over %0d settings, %0d register writes",
                 levels_sent, settings, reg_writes);
        $display("summary: %0d blocks averaged, %0d updates flagged, %0d mismatches",
                 blocks_seen, updates_seen, error_count);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
